// ===== rtl/heating_offset_tracker_core_macros.svh =====
// Assertion macros shared by the offset tracker RTL.
// Each macro takes a label, the condition that triggers the check, the
// expected consequence and the message that is reported on failure.
// Define SYNTH to compile them away.
`ifndef HEATING_OFFSET_TRACKER_CORE_MACROS_SVH
`define HEATING_OFFSET_TRACKER_CORE_MACROS_SVH

`ifndef SYNTH

// The consequence must hold in the same cycle as the trigger.
`define HOFT_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// The consequence must hold in the cycle after the trigger.
`define HOFT_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`else

`define HOFT_ASSERT_IMP(lbl, ante, cons, msg)
`define HOFT_ASSERT_NXT(lbl, ante, cons, msg)

`endif

`endif

// ===== rtl/hoft_pkg.sv =====
package hoft_pkg;

  // Field and register widths.
  localparam int OFS_W    = 24;  // signed Q8.16 offset
  localparam int LVL_W    = 15;  // clamped load level, target level
  localparam int IN_LVL_W = 16;  // signed load level on the input
  localparam int TICK_W   = 8;
  localparam int TBL_W    = 64;
  localparam int IN_W     = 24;  // input tdata, whole bytes
  localparam int OUT_W    = 24;  // output tdata, whole bytes

  // Number of anchor divisors in use (2..8).
  localparam int ANCHOR_COUNT = 8;
  localparam int IDX_W        = $clog2(ANCHOR_COUNT);
  localparam int AC_W         = $clog2(ANCHOR_COUNT + 1);
  localparam logic [AC_W-1:0] AC_VAL = AC_W'(ANCHOR_COUNT);
  // Largest k with 2**k <= ANCHOR_COUNT.
  localparam int AC_FLOOR_LOG = $clog2(ANCHOR_COUNT + 1) - 1;
  localparam int SEL_W        = 3;   // byte select within the anchor table

  // Magnitudes of offsets and differences never exceed 2**23.
  localparam int MAG_W = 24;

  // Equilibrium division: |target_offset| * level / target_level.
  localparam int EQ_STEPS = MAG_W;
  // Step division: |d| * ticks / (ANCHOR_COUNT * divisor), dividend < 2**31.
  localparam int STP_W      = MAG_W - 1 + TICK_W;
  localparam int STEP_STEPS = STP_W - AC_FLOOR_LOG;

  // Shared serial divider.
  localparam int Q_W   = (STEP_STEPS > EQ_STEPS) ? STEP_STEPS : EQ_STEPS;
  localparam int CNT_W = $clog2(Q_W);
  localparam int REM_W = LVL_W;
  localparam int DEN_W = LVL_W;

  // Width of the unsaturated update sum.
  localparam int SUM_W = Q_W + 2;

  localparam logic [OFS_W-1:0] OFS_MAX = {1'b0, {(OFS_W-1){1'b1}}};
  localparam logic [OFS_W-1:0] OFS_MIN = {1'b1, {(OFS_W-1){1'b0}}};

  // Configuration register indexes.
  localparam int CFG_ADDR_W = 2;
  localparam logic [CFG_ADDR_W-1:0] CFG_TARGET_LEVEL  = 2'd0;
  localparam logic [CFG_ADDR_W-1:0] CFG_TARGET_OFFSET = 2'd1;
  localparam logic [CFG_ADDR_W-1:0] CFG_ANCHOR_TABLE  = 2'd2;

  // Register values after reset.
  localparam logic [LVL_W-1:0] TL_RESET  = 15'd1000;
  localparam logic [OFS_W-1:0] TO_RESET  = '0;
  localparam logic [TBL_W-1:0] TBL_RESET = 64'h0101_0101_0101_0101;

  // Sequencer states.
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_EQ_MUL,
    ST_EQ_DIV,
    ST_BRANCH,
    ST_PATH,
    ST_IDX,
    ST_STEP_MUL,
    ST_STEP_DIV,
    ST_DONE
  } state_t;

endpackage

// ===== rtl/heating_offset_tracker_core.sv =====
// Self-heating offset tracker.
// Input stream (in_*): one transaction per update, carrying the load level
// (signed, clamped to 0..target_level) and the ticks elapsed since the last
// update. Output stream (out_*): exactly one transaction per input, the new
// offset estimate in signed Q8.16. Configuration (cfg_*): a plain write port
// for target_level, target_offset and the anchor divisor table; write it
// only while no update is in flight.
// Each update steps through the equilibrium multiply and division, the branch
// choice, the path fraction, the index division, the step multiply and division
// and the commit; an estimate that holds before the anchor lookup, a zero selected
// divisor or a path index that is zero at once shortens it. Both divisions share
// the single bit-per-cycle shift divider, which runs 24 steps for the
// equilibrium and 28 steps for the step size, plus a 3-step index division.
// in_tready is high only while the sequencer is idle. The output register
// lets the next update be accepted while a result still waits; if the sink
// still stalls when that update finishes, the sequencer waits in its last
// state and the estimate is not committed until the output register frees.
// Reset (synchronous, active low) clears the estimate to zero, loads the
// default registers and empties the output register.
module heating_offset_tracker_core
  import hoft_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  // Input stream.
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [IN_W-1:0]       in_tdata,   // [15:0] load_level, [23:16] elapsed_ticks
  // Output stream.
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [OUT_W-1:0]      out_tdata,  // [23:0] offset_now
  // Configuration write port.
  input  logic                  cfg_wen,
  input  logic [CFG_ADDR_W-1:0] cfg_addr,
  input  logic [TBL_W-1:0]      cfg_wdata
);

  `include "heating_offset_tracker_core_macros.svh"

  // Control state.
  state_t state_r, state_nxt;
  logic   out_tvalid_r, out_tvalid_nxt;
  logic [OFS_W-1:0] est_r, est_nxt;
  logic [LVL_W-1:0] tl_r, tl_nxt;
  logic [OFS_W-1:0] to_r, to_nxt;
  logic [TBL_W-1:0] tbl_r, tbl_nxt;

  // Datapath registers.
  logic [OUT_W-1:0] out_tdata_r, out_tdata_nxt;
  logic [LVL_W-1:0] lvl_r, lvl_nxt;
  logic [TICK_W-1:0] ticks_r, ticks_nxt;
  logic [Q_W-1:0]   div_q_r, div_q_nxt;
  logic [REM_W-1:0] div_rem_r, div_rem_nxt;
  logic [DEN_W-1:0] div_den_r, div_den_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             decay_r, decay_nxt;
  logic [OFS_W-1:0] eq_r, eq_nxt;
  logic [MAG_W-1:0] dmag_r, dmag_nxt;
  logic [MAG_W-1:0] idx_rem_r, idx_rem_nxt;
  logic [IDX_W-1:0] idx_q_r, idx_q_nxt;
  logic             sub_r, sub_nxt;
  logic             upd_r, upd_nxt;

  // Input field split and level clamp.
  logic [IN_LVL_W-1:0] in_lvl;
  logic [TICK_W-1:0]   in_ticks;
  logic [LVL_W-1:0]    lvl_clamped;

  assign in_lvl   = in_tdata[IN_LVL_W-1:0];
  assign in_ticks = in_tdata[IN_LVL_W+TICK_W-1:IN_LVL_W];

  always_comb begin
    if (in_lvl[IN_LVL_W-1]) begin
      lvl_clamped = '0;
    end else if (in_lvl[LVL_W-1:0] > tl_r) begin
      lvl_clamped = tl_r;
    end else begin
      lvl_clamped = in_lvl[LVL_W-1:0];
    end
  end

  // Equilibrium product |target_offset| * level.
  logic [MAG_W-1:0]       to_mag;
  logic [MAG_W+LVL_W-1:0] eq_prod;

  assign to_mag  = to_r[OFS_W-1] ? (~to_r + 1'b1) : to_r;
  assign eq_prod = to_mag * lvl_r;

  // One restoring step of the shared shift divider.
  logic [REM_W:0]   div_sh;
  logic [REM_W:0]   div_diff;
  logic             div_ge;
  logic [REM_W-1:0] div_rem_step;
  logic [Q_W-1:0]   div_q_step;

  assign div_sh       = {div_rem_r, div_q_r[Q_W-1]};
  assign div_diff     = div_sh - {1'b0, div_den_r};
  assign div_ge       = div_sh >= {1'b0, div_den_r};
  assign div_rem_step = div_ge ? div_diff[REM_W-1:0] : div_sh[REM_W-1:0];
  assign div_q_step   = Q_W'({div_q_r, div_ge});

  // Signed equilibrium and branch choice.
  logic [MAG_W-1:0] eq_mag;
  logic [OFS_W-1:0] eq_val;
  logic [MAG_W-1:0] est_mag;

  assign eq_mag  = div_q_r[MAG_W-1:0];
  assign eq_val  = to_r[OFS_W-1] ? (~eq_mag + 1'b1) : eq_mag;
  assign est_mag = est_r[OFS_W-1] ? (~est_r + 1'b1) : est_r;

  // Path fraction num/d: hold, index zero or a short division.
  logic signed [OFS_W:0] to_x, eq_x, est_x;
  logic signed [OFS_W:0] d_val, n_val;
  logic                  d_neg;
  logic                  path_hold;
  logic                  path_zero;
  logic [OFS_W:0]        d_abs, n_abs;
  logic [MAG_W+AC_W-1:0] idx_a;

  assign to_x  = $signed({to_r[OFS_W-1], to_r});
  assign eq_x  = $signed({eq_r[OFS_W-1], eq_r});
  assign est_x = $signed({est_r[OFS_W-1], est_r});
  assign d_val = decay_r ? (to_x - eq_x) : eq_x;
  assign n_val = decay_r ? (to_x - est_x) : est_x;
  assign d_neg = d_val[OFS_W];

  assign path_hold = (d_val == '0) || (!d_neg && (n_val >= d_val)) ||
                     (d_neg && (n_val <= d_val));
  assign path_zero = (!d_neg && n_val[OFS_W]) ||
                     (d_neg && !n_val[OFS_W] && (n_val != '0));

  assign d_abs = d_neg ? (~d_val + 1'b1) : d_val;
  assign n_abs = n_val[OFS_W] ? (~n_val + 1'b1) : n_val;
  assign idx_a = n_abs[MAG_W-1:0] * AC_VAL;

  // One restoring step of the index division.
  logic [MAG_W:0]   idx_sh;
  logic [MAG_W:0]   idx_diff;
  logic             idx_ge;
  logic [MAG_W-1:0] idx_rem_step;

  assign idx_sh       = {idx_rem_r, idx_q_r[IDX_W-1]};
  assign idx_diff     = idx_sh - {1'b0, dmag_r};
  assign idx_ge       = idx_sh >= {1'b0, dmag_r};
  assign idx_rem_step = idx_ge ? idx_diff[MAG_W-1:0] : idx_sh[MAG_W-1:0];

  // Anchor divisor and step product |d| * ticks.
  logic [SEL_W-1:0]        a_sel;
  logic [7:0]              abyte;
  logic [DEN_W-1:0]        step_den;
  logic [MAG_W+TICK_W-1:0] step_prod;

  assign a_sel     = SEL_W'(idx_q_r);
  assign abyte     = tbl_r[{a_sel, 3'b000} +: 8];
  assign step_den  = DEN_W'(abyte) * DEN_W'(AC_VAL);
  assign step_prod = dmag_r * ticks_r;

  // Final update with saturation to the offset range.
  logic [SUM_W-1:0] est_s, q_s, sum_v;
  logic             sum_pos_ovf, sum_neg_ovf;
  logic [OFS_W-1:0] sat_v, new_val;

  assign est_s = {{(SUM_W-OFS_W){est_r[OFS_W-1]}}, est_r};
  assign q_s   = {{(SUM_W-STEP_STEPS){1'b0}}, div_q_r[STEP_STEPS-1:0]};
  assign sum_v = sub_r ? (est_s - q_s) : (est_s + q_s);

  assign sum_pos_ovf = !sum_v[SUM_W-1] && (|sum_v[SUM_W-2:OFS_W-1]);
  assign sum_neg_ovf = sum_v[SUM_W-1] && !(&sum_v[SUM_W-2:OFS_W-1]);

  always_comb begin
    if (sum_pos_ovf) begin
      sat_v = OFS_MAX;
    end else if (sum_neg_ovf) begin
      sat_v = OFS_MIN;
    end else begin
      sat_v = sum_v[OFS_W-1:0];
    end
  end

  assign new_val = upd_r ? sat_v : est_r;

  // Sequencer: next state and next register values.
  always_comb begin
    state_nxt      = state_r;
    out_tvalid_nxt = out_tvalid_r && !out_tready;
    out_tdata_nxt  = out_tdata_r;
    est_nxt        = est_r;
    tl_nxt         = tl_r;
    to_nxt         = to_r;
    tbl_nxt        = tbl_r;
    lvl_nxt        = lvl_r;
    ticks_nxt      = ticks_r;
    div_q_nxt      = div_q_r;
    div_rem_nxt    = div_rem_r;
    div_den_nxt    = div_den_r;
    cnt_nxt        = cnt_r;
    decay_nxt      = decay_r;
    eq_nxt         = eq_r;
    dmag_nxt       = dmag_r;
    idx_rem_nxt    = idx_rem_r;
    idx_q_nxt      = idx_q_r;
    sub_nxt        = sub_r;
    upd_nxt        = upd_r;

    // Configuration writes must arrive only while the sequencer is idle; not enforced.
    if (cfg_wen) begin
      case (cfg_addr)
        CFG_TARGET_LEVEL:  tl_nxt  = cfg_wdata[LVL_W-1:0];
        CFG_TARGET_OFFSET: to_nxt  = cfg_wdata[OFS_W-1:0];
        CFG_ANCHOR_TABLE:  tbl_nxt = cfg_wdata;
        default: ;
      endcase
    end

    case (state_r)
      ST_IDLE: begin
        if (in_tvalid) begin
          lvl_nxt   = lvl_clamped;
          ticks_nxt = in_ticks;
          state_nxt = ST_EQ_MUL;
        end
      end

      // Load the divider with the equilibrium product; a zero target
      // level gives a zero equilibrium without dividing.
      ST_EQ_MUL: begin
        div_rem_nxt = REM_W'(eq_prod >> EQ_STEPS);
        div_q_nxt   = Q_W'(eq_prod[EQ_STEPS-1:0]) << (Q_W - EQ_STEPS);
        div_den_nxt = tl_r;
        cnt_nxt     = CNT_W'(EQ_STEPS - 1);
        if (tl_r == '0) begin
          div_q_nxt = '0;
          state_nxt = ST_BRANCH;
        end else begin
          state_nxt = ST_EQ_DIV;
        end
      end

      ST_EQ_DIV: begin
        div_rem_nxt = div_rem_step;
        div_q_nxt   = div_q_step;
        cnt_nxt     = cnt_r - 1'b1;
        if (cnt_r == '0) begin
          state_nxt = ST_BRANCH;
        end
      end

      // Sign the equilibrium and choose between decay and rise.
      ST_BRANCH: begin
        eq_nxt    = eq_val;
        decay_nxt = est_mag > eq_mag;
        state_nxt = ST_PATH;
      end

      ST_PATH: begin
        dmag_nxt    = d_abs[MAG_W-1:0];
        sub_nxt     = decay_r ^ d_neg;
        idx_rem_nxt = MAG_W'(idx_a >> IDX_W);
        idx_q_nxt   = idx_a[IDX_W-1:0];
        cnt_nxt     = CNT_W'(IDX_W - 1);
        upd_nxt     = 1'b0;
        if (path_hold) begin
          state_nxt = ST_DONE;
        end else if (path_zero) begin
          idx_q_nxt = '0;
          state_nxt = ST_STEP_MUL;
        end else begin
          state_nxt = ST_IDX;
        end
      end

      ST_IDX: begin
        idx_rem_nxt = idx_rem_step;
        idx_q_nxt   = IDX_W'({idx_q_r, idx_ge});
        cnt_nxt     = cnt_r - 1'b1;
        if (cnt_r == '0) begin
          state_nxt = ST_STEP_MUL;
        end
      end

      // Look up the divisor and load the step product; a zero divisor holds.
      ST_STEP_MUL: begin
        div_rem_nxt = REM_W'(step_prod[STP_W-1:0] >> STEP_STEPS);
        div_q_nxt   = Q_W'(step_prod[STEP_STEPS-1:0]) << (Q_W - STEP_STEPS);
        div_den_nxt = step_den;
        cnt_nxt     = CNT_W'(STEP_STEPS - 1);
        if (abyte == '0) begin
          state_nxt = ST_DONE;
        end else begin
          upd_nxt   = 1'b1;
          state_nxt = ST_STEP_DIV;
        end
      end

      ST_STEP_DIV: begin
        div_rem_nxt = div_rem_step;
        div_q_nxt   = div_q_step;
        cnt_nxt     = cnt_r - 1'b1;
        if (cnt_r == '0) begin
          state_nxt = ST_DONE;
        end
      end

      // Commit the estimate once the output register is free.
      ST_DONE: begin
        if (!out_tvalid_r || out_tready) begin
          est_nxt        = new_val;
          out_tdata_nxt  = new_val;
          out_tvalid_nxt = 1'b1;
          state_nxt      = ST_IDLE;
        end
      end

      default: state_nxt = ST_IDLE;
    endcase
  end

  // State register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Control registers with a reset value.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_tvalid_r <= 1'b0;
      est_r        <= '0;
      tl_r         <= TL_RESET;
      to_r         <= TO_RESET;
      tbl_r        <= TBL_RESET;
    end else begin
      out_tvalid_r <= out_tvalid_nxt;
      est_r        <= est_nxt;
      tl_r         <= tl_nxt;
      to_r         <= to_nxt;
      tbl_r        <= tbl_nxt;
    end
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    out_tdata_r <= out_tdata_nxt;
    lvl_r       <= lvl_nxt;
    ticks_r     <= ticks_nxt;
    div_q_r     <= div_q_nxt;
    div_rem_r   <= div_rem_nxt;
    div_den_r   <= div_den_nxt;
    cnt_r       <= cnt_nxt;
    decay_r     <= decay_nxt;
    eq_r        <= eq_nxt;
    dmag_r      <= dmag_nxt;
    idx_rem_r   <= idx_rem_nxt;
    idx_q_r     <= idx_q_nxt;
    sub_r       <= sub_nxt;
    upd_r       <= upd_nxt;
  end

  assign in_tready  = (state_r == ST_IDLE);
  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;

  // The shared divider is stepping in either of its two phases.
  logic div_run;

  assign div_run = (state_r == ST_EQ_DIV) || (state_r == ST_STEP_DIV);

  // Checks on the sequencer and the serial dividers.
  `HOFT_ASSERT_NXT(a_busy_after_accept, in_tvalid && in_tready, !in_tready, "accept while busy")
  `HOFT_ASSERT_IMP(a_out_is_estimate, out_tvalid_r, out_tdata_r == est_r, "output not estimate")
  `HOFT_ASSERT_IMP(a_div_rem_bound, div_run, div_rem_r < div_den_r, "divider remainder")
  `HOFT_ASSERT_IMP(a_idx_rem_bound, state_r == ST_IDX, idx_rem_r < dmag_r, "index remainder")

endmodule

// ===== tb/testbench.sv =====
`timescale 1ns / 100ps

module testbench;
  import hoft_pkg::*;

  localparam longint OFS_HI          = longint'($signed(OFS_MAX));
  localparam longint OFS_LO          = longint'($signed(OFS_MIN));
  localparam int     RANDOM_PHASES   = 10;
  localparam int     ITEMS_PER_PHASE = 155;
  // Longest update plus margin, waited out before a register write.
  localparam int     SETTLE_CYCLES   = 70;
  localparam int     PLAN_ROWS       = 32;

  typedef enum logic {ROW_WRITE, ROW_ITEM} row_kind_t;

  typedef struct packed {
    row_kind_t             kind;
    logic [CFG_ADDR_W-1:0] addr;
    logic [TBL_W-1:0]      value;
    logic [15:0]           level;
    logic [7:0]            ticks;
    logic                  known;
    logic [OFS_W-1:0]      want;
  } plan_row_t;

  logic                  clk = 1'b0;
  logic                  rst_n;
  logic                  in_tvalid;
  logic                  in_tready;
  logic [IN_W-1:0]       in_tdata;   // [15:0] load_level, [23:16] elapsed_ticks
  logic                  out_tvalid;
  logic                  out_tready;
  logic [OUT_W-1:0]      out_tdata;  // [23:0] offset_now
  logic                  cfg_wen;
  logic [CFG_ADDR_W-1:0] cfg_addr;
  logic [TBL_W-1:0]      cfg_wdata;

  // Predicted copy of the registers and of the running offset estimate.
  longint           level_target  = longint'(TL_RESET);
  longint           offset_target = longint'($signed(TO_RESET));
  logic [TBL_W-1:0] divisor_table = TBL_RESET;
  longint           offset_est    = 0;

  // Offsets still owed by the block, oldest first.
  logic [OFS_W-1:0] offset_q[$];
  logic [OFS_W-1:0] offset_want;
  bit               mismatch_seen = 1'b0;
  // While set, neither side inserts idle cycles.
  bit               calm = 1'b0;

  plan_row_t directed_plan [PLAN_ROWS];

  heating_offset_tracker_core i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_wen    (cfg_wen),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata)
  );

  always #6 clk = ~clk;

  function automatic longint magnitude(longint v);
    return (v < 0) ? -v : v;
  endfunction

  function automatic longint clamp_offset(longint v);
    if (v > OFS_HI) return OFS_HI;
    if (v < OFS_LO) return OFS_LO;
    return v;
  endfunction

  // Anchor slot for the fraction n/d of the path covered, or -1 once the
  // fraction has reached one. A negative fraction maps to the first slot.
  function automatic int path_slot(longint n, longint d);
    if (d > 0) begin
      if (n >= d) return -1;
      if (n < 0) return 0;
    end else begin
      if (n <= d) return -1;
      if (n > 0) return 0;
    end
    return int'((magnitude(n) * ANCHOR_COUNT) / magnitude(d));
  endfunction

  function automatic longint anchor_divisor(int slot);
    return longint'(divisor_table[8*(slot % 8) +: 8]);
  endfunction

  // Moves the estimate one update along and returns the new offset.
  function automatic logic [OFS_W-1:0] advance_offset(logic [15:0] level_in,
                                                      logic [7:0] ticks_in);
    longint lvl, tick, eq, d, dv, cur;
    int     slot;
    lvl  = longint'($signed(level_in));
    tick = longint'(ticks_in);
    cur  = offset_est;
    eq   = 0;
    if (lvl > level_target) lvl = level_target;
    if (lvl < 0) lvl = 0;
    if (level_target != 0) eq = (offset_target * lvl) / level_target;
    if (magnitude(cur) > magnitude(eq)) begin
      // Decay towards the equilibrium.
      d = offset_target - eq;
      if (d != 0) begin
        slot = path_slot(offset_target - cur, d);
        if (slot >= 0) begin
          dv = anchor_divisor(slot);
          if (dv != 0) cur = clamp_offset(cur - (d * tick) / (ANCHOR_COUNT * dv));
        end
      end
    end else if (eq != 0) begin
      // Rise towards the equilibrium.
      slot = path_slot(cur, eq);
      if (slot >= 0) begin
        dv = anchor_divisor(slot);
        if (dv != 0) cur = clamp_offset(cur + (eq * tick) / (ANCHOR_COUNT * dv));
      end
    end
    offset_est = cur;
    return cur[OFS_W-1:0];
  endfunction

  function automatic plan_row_t wr(logic [CFG_ADDR_W-1:0] addr, logic [TBL_W-1:0] value);
    return '{ROW_WRITE, addr, value, 16'd0, 8'd0, 1'b0, '0};
  endfunction

  function automatic plan_row_t go(logic [15:0] level, logic [7:0] ticks);
    return '{ROW_ITEM, CFG_TARGET_LEVEL, '0, level, ticks, 1'b0, '0};
  endfunction

  function automatic plan_row_t go_known(logic [15:0] level, logic [7:0] ticks,
                                         logic [OFS_W-1:0] want);
    return '{ROW_ITEM, CFG_TARGET_LEVEL, '0, level, ticks, 1'b1, want};
  endfunction

  function automatic logic [15:0] pick_level();
    case ($urandom_range(0, 9))
      0: return 16'($urandom);
      1: return 16'h8000 | 16'($urandom);
      2: return 16'd0;
      3: return 16'(level_target);
      4: return 16'(level_target + $urandom_range(1, 200));
      default: return 16'($urandom_range(0, 32'(level_target)));
    endcase
  endfunction

  function automatic logic [7:0] pick_ticks();
    case ($urandom_range(0, 9))
      0: return 8'hFF;
      1: return 8'd0;
      2, 3, 4, 5: return 8'($urandom_range(0, 15));
      default: return 8'($urandom);
    endcase
  endfunction

  // One register write; the predicted copy follows it.
  task automatic write_reg(logic [CFG_ADDR_W-1:0] addr, logic [TBL_W-1:0] value);
    cfg_wen   <= 1'b1;
    cfg_addr  <= addr;
    cfg_wdata <= value;
    @(negedge clk);
    cfg_wen <= 1'b0;
    @(negedge clk);
    case (addr)
      CFG_TARGET_LEVEL:  level_target  = longint'(value[LVL_W-1:0]);
      CFG_TARGET_OFFSET: offset_target = longint'($signed(value[OFS_W-1:0]));
      CFG_ANCHOR_TABLE:  divisor_table = value;
      default: ;
    endcase
  endtask

  // Holds the input back until every owed offset has come out.
  task automatic settle(bit before_write);
    in_tvalid <= 1'b0;
    while (offset_q.size() != 0) @(negedge clk);
    if (before_write) repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  // Offers one update and records the offset it must produce.
  task automatic send_item(logic [15:0] level, logic [7:0] ticks, bit known,
                           logic [OFS_W-1:0] want);
    int unsigned      gap;
    logic [OFS_W-1:0] predicted;
    gap = calm ? 0 : $urandom_range(0, 15);
    if (gap != 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {ticks, level};
    do @(posedge clk); while (!in_tready);
    predicted = advance_offset(level, ticks);
    offset_q.push_back(known ? want : predicted);
    @(negedge clk);
  endtask

  // Fresh random settings, extremes included.
  task automatic pick_settings();
    logic [LVL_W-1:0] lvl;
    logic [OFS_W-1:0] ofs;
    logic [TBL_W-1:0] tbl;
    case ($urandom_range(0, 7))
      0: lvl = 15'd1;
      1: lvl = 15'h7FFF;
      2: lvl = 15'd0;
      3, 4: lvl = 15'($urandom_range(1, 64));
      default: lvl = 15'($urandom_range(1, 32767));
    endcase
    case ($urandom_range(0, 5))
      0: ofs = OFS_MAX;
      1: ofs = OFS_MIN;
      2: ofs = 24'($urandom_range(0, 4000)) - 24'd2000;
      default: ofs = 24'($urandom);
    endcase
    case ($urandom_range(0, 5))
      0: tbl = {8{8'h01}};
      1: tbl = {8{8'hFF}};
      2: tbl = {$urandom, $urandom};
      default: begin
        for (int i = 0; i < 8; i++) tbl[8*i +: 8] = 8'($urandom_range(1, 255));
      end
    endcase
    write_reg(CFG_TARGET_LEVEL, 64'(lvl));
    write_reg(CFG_TARGET_OFFSET, 64'(ofs));
    write_reg(CFG_ANCHOR_TABLE, tbl);
  endtask

  // Result side: random back-pressure before each transaction.
  initial begin
    int unsigned stall;
    out_tready = 1'b0;
    @(posedge rst_n);
    forever begin
      stall = calm ? 0 : $urandom_range(0, 15);
      if (stall != 0) begin
        out_tready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      out_tready <= 1'b1;
      do @(posedge clk); while (!out_tvalid);
      @(negedge clk);
    end
  end

  // Compare every accepted result with the oldest owed offset.
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      if (offset_q.size() == 0) begin
        $error("offset_now: expected no transaction, got %0d",
               $signed(out_tdata[OFS_W-1:0]));
        mismatch_seen = 1'b1;
      end else begin
        offset_want = offset_q.pop_front();
        if (out_tdata[OFS_W-1:0] !== offset_want) begin
          $error("offset_now: expected %0d, got %0d", $signed(offset_want),
                 $signed(out_tdata[OFS_W-1:0]));
          mismatch_seen = 1'b1;
        end
      end
    end
  end

  // Stimulus.
  initial begin
    int          sent;
    int          run_len;
    logic [15:0] run_level;
    rst_n     = 1'b0;
    in_tvalid = 1'b0;
    in_tdata  = '0;
    cfg_wen   = 1'b0;
    cfg_addr  = '0;
    cfg_wdata = '0;

    directed_plan = '{
      // Zero target offset after reset: the estimate never leaves zero.
      go_known(16'd0, 8'd0, '0),
      go_known(16'h7FFF, 8'hFF, '0),
      go_known(16'h8000, 8'hFF, '0),
      // Full positive target: the first step overshoots and saturates,
      // then the estimate holds at the equilibrium.
      wr(CFG_TARGET_OFFSET, 64'(OFS_MAX)),
      go_known(16'd1000, 8'hFF, OFS_MAX),
      go_known(16'd1000, 8'd1, OFS_MAX),
      go(16'd0, 8'd1),
      go(-16'sd5, 8'd200),
      go(16'd500, 8'd3),
      // Largest level range and full negative target.
      wr(CFG_TARGET_LEVEL, 64'h7FFF),
      wr(CFG_TARGET_OFFSET, 64'(OFS_MIN)),
      go(16'h7FFF, 8'hFF),
      go(16'd16383, 8'd2),
      go(16'd16383, 8'd2),
      // Zero divisor in the first slot.
      wr(CFG_ANCHOR_TABLE, 64'h00FF_0000_0102_0400),
      go(16'd0, 8'd10),
      go(16'd0, 8'hFF),
      // Every divisor zero: the estimate holds.
      wr(CFG_ANCHOR_TABLE, 64'd0),
      go(16'd100, 8'hFF),
      wr(CFG_ANCHOR_TABLE, {8{8'hFF}}),
      go(16'h7FFF, 8'hFF),
      // Zero target level: the equilibrium is zero.
      wr(CFG_TARGET_LEVEL, 64'd0),
      go(16'd123, 8'hFF),
      go(16'hFFFF, 8'hFF),
      // Smallest target level, small target offset.
      wr(CFG_TARGET_LEVEL, 64'd1),
      wr(CFG_TARGET_OFFSET, 64'd100),
      go(16'd1, 8'd0),
      go(16'd2, 8'd17),
      go(16'd1, 8'hFF),
      go(16'd0, 8'd0),
      wr(CFG_ANCHOR_TABLE, TBL_RESET),
      go(16'd1, 8'd7)
    };

    repeat (11) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed part.
    for (int r = 0; r < PLAN_ROWS; r++) begin
      if (directed_plan[r].kind == ROW_WRITE) begin
        settle(1'b1);
        write_reg(directed_plan[r].addr, directed_plan[r].value);
      end else begin
        send_item(directed_plan[r].level, directed_plan[r].ticks,
                  directed_plan[r].known, directed_plan[r].want);
      end
    end

    // Random part: runs of a steady load so the estimate walks the path.
    for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
      settle(1'b1);
      pick_settings();
      calm = ($urandom_range(0, 3) == 0);
      sent = 0;
      while (sent < ITEMS_PER_PHASE) begin
        run_level = pick_level();
        run_len   = $urandom_range(1, 24);
        for (int k = 0; k < run_len && sent < ITEMS_PER_PHASE; k++) begin
          send_item(run_level, pick_ticks(), 1'b0, '0);
          sent++;
          if ($urandom_range(0, 99) == 0) settle(1'b0);
        end
        if ($urandom_range(0, 7) == 0) calm = !calm;
      end
    end

    settle(1'b1);
    if (!mismatch_seen) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

  // Watchdog well beyond the slowest correct run.
  initial begin
    #(10_000_000);
    $display("FAIL");
    $finish;
  end

endmodule

// ===== filelist.f =====
+incdir+rtl
rtl/hoft_pkg.sv
rtl/heating_offset_tracker_core.sv
tb/testbench.sv
